>>> hdl/dqp_pkg.sv
package dqp_pkg;

  localparam int MAX_MESSAGE = 512;
  localparam int MAX_NAME    = 255;
  localparam int POS_W       = $clog2(MAX_MESSAGE + 1);
  localparam int HEADER_LEN  = 12;

  localparam int Q_DEPTH = 4;
  localparam int Q_IDX_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONSTD = 2'd1;
  localparam logic [1:0] ST_TRUNC  = 2'd2;
  localparam logic [1:0] ST_LONG   = 2'd3;

  localparam logic       KIND_CHAR    = 1'b0;
  localparam logic       KIND_SUMMARY = 1'b1;
  localparam logic [7:0] DOT_CHAR     = 8'h2E;

  typedef struct packed {
    logic        kind;
    logic [7:0]  name_char;
    logic [1:0]  status;
    logic [15:0] query_id;
    logic [15:0] flag_bits;
    logic [15:0] question_count;
    logic [15:0] answer_count;
    logic [15:0] authority_count;
    logic [15:0] additional_count;
    logic [15:0] query_type;
    logic [15:0] query_class;
    logic [7:0]  name_length;
  } result_t;

endpackage

>>> hdl/dns_query_parser.sv
// dns query parser: takes one message byte per request, in wire order, with last_byte marking
// the end of the message. the 12-byte header (id, flags, four counts) is captured; if QR and
// opcode are zero the first question name is walked and its characters are sent out one per
// result in dotted form, followed by QTYPE and QCLASS. the last byte always produces a summary
// result (status, header words, type, class, name length) and returns the parser to its reset
// state. a byte that is both a name character and the last byte gives the character first,
// then the summary. rate: one byte per cycle while in_ready is high; a result is visible the cycle
// after its byte is taken when the queue was empty. each byte updates the parse state and its
// results go into a four-entry result queue, and in_ready is high while that queue has room
// for two results, so the sustained rate is set by the output side draining one result per cycle.
module dns_query_parser
  import dqp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [7:0]  out_name_char,
  output logic [1:0]  out_status,
  output logic [15:0] out_query_id,
  output logic [15:0] out_flag_bits,
  output logic [15:0] out_question_count,
  output logic [15:0] out_answer_count,
  output logic [15:0] out_authority_count,
  output logic [15:0] out_additional_count,
  output logic [15:0] out_query_type,
  output logic [15:0] out_query_class,
  output logic [7:0]  out_name_length
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_NAME,
    PH_TAIL,
    PH_DONE
  } phase_t;

  // parse state
  logic [POS_W-1:0] pos_r, pos_nxt;
  phase_t           phase_r, phase_nxt;
  logic [15:0]      id_r, id_nxt;
  logic [15:0]      flags_r, flags_nxt;
  logic [15:0]      cnt_r [4];
  logic [15:0]      cnt_nxt [4];
  logic [6:0]       lab_rem_r, lab_rem_nxt;
  logic             first_r, first_nxt;
  logic [7:0]       chars_r, chars_nxt;
  logic [15:0]      tc_r [2];
  logic [15:0]      tc_nxt [2];
  logic [1:0]       err_r, err_nxt;

  // result queue
  result_t            q_r [Q_DEPTH];
  logic [Q_IDX_W-1:0] head_r, head_nxt;
  logic [Q_IDX_W-1:0] tail_r, tail_nxt;
  logic [Q_CNT_W-1:0] qcnt_r, qcnt_nxt;

  logic       take;
  logic       pop;
  logic       want_chr;
  logic [7:0] chr_byte;
  logic       emit_chr;
  logic [1:0] cnt_idx;
  logic [1:0] k;
  logic [1:0] sum_status;
  result_t    chr_res;
  result_t    sum_res;
  result_t    res0;
  result_t    res1;
  logic [1:0] n_push;

  // room for two results keeps a char plus summary from overflowing the queue
  assign in_ready = (qcnt_r <= Q_CNT_W'(Q_DEPTH - 2));
  assign take     = in_valid && in_ready;
  assign out_valid = (qcnt_r != '0);
  assign pop      = out_valid && out_ready;

  // which count word a header byte lands in (bytes 4..11)
  assign cnt_idx = 2'(pos_r[2:1] - 2'd2);
  assign k       = lab_rem_r[1:0];

  always_comb begin
    pos_nxt     = pos_r;
    phase_nxt   = phase_r;
    id_nxt      = id_r;
    flags_nxt   = flags_r;
    cnt_nxt     = cnt_r;
    lab_rem_nxt = lab_rem_r;
    first_nxt   = first_r;
    chars_nxt   = chars_r;
    tc_nxt      = tc_r;
    err_nxt     = err_r;
    want_chr    = 1'b0;
    chr_byte    = in_data_byte;
    emit_chr    = 1'b0;

    if (take && (pos_r < POS_W'(MAX_MESSAGE))) begin
      pos_nxt = pos_r + 1'b1;
      unique case (phase_r)
        PH_HEADER: begin
          if (pos_r < POS_W'(2)) begin
            if (pos_r[0]) id_nxt[7:0] = in_data_byte;
            else id_nxt[15:8] = in_data_byte;
          end else if (pos_r < POS_W'(4)) begin
            if (pos_r[0]) flags_nxt[7:0] = in_data_byte;
            else flags_nxt[15:8] = in_data_byte;
          end else if (pos_r < POS_W'(HEADER_LEN)) begin
            if (pos_r[0]) cnt_nxt[cnt_idx][7:0] = in_data_byte;
            else cnt_nxt[cnt_idx][15:8] = in_data_byte;
          end
          if (pos_r == POS_W'(HEADER_LEN - 1)) begin
            // flags are complete by now; QR or a nonzero opcode stops the parse
            if (flags_r[15] || (flags_r[14:11] != 4'h0)) begin
              err_nxt   = ST_NONSTD;
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_NAME;
            end
          end
        end
        PH_NAME: begin
          if (lab_rem_r != '0) begin
            want_chr    = 1'b1;
            lab_rem_nxt = lab_rem_r - 1'b1;
          end else if ((in_data_byte == 8'h00) || in_data_byte[7]) begin
            // end of name, also for pointers and reserved label types
            phase_nxt   = PH_TAIL;
            lab_rem_nxt = '0;
          end else begin
            if (!first_r) begin
              want_chr = 1'b1;
              chr_byte = DOT_CHAR;
            end
            first_nxt   = 1'b0;
            lab_rem_nxt = in_data_byte[6:0];
          end
        end
        PH_TAIL: begin
          // label counter doubles as the type/class byte index
          if (k[0]) tc_nxt[k[1]][7:0] = in_data_byte;
          else tc_nxt[k[1]][15:8] = in_data_byte;
          if (k == 2'd3) begin
            phase_nxt   = PH_DONE;
            lab_rem_nxt = '0;
          end else begin
            lab_rem_nxt = 7'(k + 2'd1);
          end
        end
        PH_DONE: begin
          // trailing bytes are ignored
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase

      // name length limit: drop the character and flag it
      if (want_chr) begin
        if (chars_r >= 8'(MAX_NAME)) begin
          if (err_r == ST_OK) err_nxt = ST_LONG;
        end else begin
          emit_chr  = 1'b1;
          chars_nxt = chars_r + 1'b1;
        end
      end
    end

    // summary status priority
    if (err_nxt == ST_NONSTD) sum_status = ST_NONSTD;
    else if (phase_nxt != PH_DONE) sum_status = ST_TRUNC;
    else if (err_nxt == ST_LONG) sum_status = ST_LONG;
    else sum_status = ST_OK;

    chr_res           = '0;
    chr_res.kind      = KIND_CHAR;
    chr_res.name_char = chr_byte;

    sum_res                  = '0;
    sum_res.kind             = KIND_SUMMARY;
    sum_res.status           = sum_status;
    sum_res.query_id         = id_nxt;
    sum_res.flag_bits        = flags_nxt;
    sum_res.question_count   = cnt_nxt[0];
    sum_res.answer_count     = cnt_nxt[1];
    sum_res.authority_count  = cnt_nxt[2];
    sum_res.additional_count = cnt_nxt[3];
    sum_res.query_type       = tc_nxt[0];
    sum_res.query_class      = tc_nxt[1];
    sum_res.name_length      = chars_nxt;

    res0   = emit_chr ? chr_res : sum_res;
    res1   = sum_res;
    n_push = {1'b0, emit_chr} + {1'b0, take && in_last_byte};

    // message end puts everything back to reset
    if (take && in_last_byte) begin
      pos_nxt     = '0;
      phase_nxt   = PH_HEADER;
      id_nxt      = '0;
      flags_nxt   = '0;
      cnt_nxt     = '{default: '0};
      lab_rem_nxt = '0;
      first_nxt   = 1'b1;
      chars_nxt   = '0;
      tc_nxt      = '{default: '0};
      err_nxt     = ST_OK;
    end

    tail_nxt = tail_r + Q_IDX_W'(n_push);
    head_nxt = head_r + Q_IDX_W'(pop);
    qcnt_nxt = qcnt_r + Q_CNT_W'(n_push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      phase_r   <= PH_HEADER;
      id_r      <= '0;
      flags_r   <= '0;
      cnt_r     <= '{default: '0};
      lab_rem_r <= '0;
      first_r   <= 1'b1;
      chars_r   <= '0;
      tc_r      <= '{default: '0};
      err_r     <= ST_OK;
      head_r    <= '0;
      tail_r    <= '0;
      qcnt_r    <= '0;
    end else begin
      pos_r     <= pos_nxt;
      phase_r   <= phase_nxt;
      id_r      <= id_nxt;
      flags_r   <= flags_nxt;
      cnt_r     <= cnt_nxt;
      lab_rem_r <= lab_rem_nxt;
      first_r   <= first_nxt;
      chars_r   <= chars_nxt;
      tc_r      <= tc_nxt;
      err_r     <= err_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      qcnt_r    <= qcnt_nxt;
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) q_r[tail_r] <= res0;
    if (n_push == 2'd2) q_r[Q_IDX_W'(tail_r + 1'b1)] <= res1;
  end

  assign out_result_kind      = q_r[head_r].kind;
  assign out_name_char        = q_r[head_r].name_char;
  assign out_status           = q_r[head_r].status;
  assign out_query_id         = q_r[head_r].query_id;
  assign out_flag_bits        = q_r[head_r].flag_bits;
  assign out_question_count   = q_r[head_r].question_count;
  assign out_answer_count     = q_r[head_r].answer_count;
  assign out_authority_count  = q_r[head_r].authority_count;
  assign out_additional_count = q_r[head_r].additional_count;
  assign out_query_type       = q_r[head_r].query_type;
  assign out_query_class      = q_r[head_r].query_class;
  assign out_name_length      = q_r[head_r].name_length;

endmodule

>>> verif/tb_top.sv
module tb_top
  import dqp_pkg::*;
();

  // parse phases of the local prediction
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_NAME,
    PH_TAIL,
    PH_DONE
  } phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_result_kind;
  logic [7:0]  out_name_char;
  logic [1:0]  out_status;
  logic [15:0] out_query_id;
  logic [15:0] out_flag_bits;
  logic [15:0] out_question_count;
  logic [15:0] out_answer_count;
  logic [15:0] out_authority_count;
  logic [15:0] out_additional_count;
  logic [15:0] out_query_type;
  logic [15:0] out_query_class;
  logic [7:0]  out_name_length;

  dns_query_parser dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .in_last_byte         (in_last_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_result_kind      (out_result_kind),
    .out_name_char        (out_name_char),
    .out_status           (out_status),
    .out_query_id         (out_query_id),
    .out_flag_bits        (out_flag_bits),
    .out_question_count   (out_question_count),
    .out_answer_count     (out_answer_count),
    .out_authority_count  (out_authority_count),
    .out_additional_count (out_additional_count),
    .out_query_type       (out_query_type),
    .out_query_class      (out_query_class),
    .out_name_length      (out_name_length)
  );

  always #5 clk = ~clk;

  // idling knobs, percent of cycles
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // long receiver hold-off, counted down by the result side
  int ready_hold = 0;
  int mismatch_count = 0;

  // results predicted but not yet seen, oldest first
  result_t expected_results[$];
  // bytes of the message being built
  logic [7:0] msg_bytes[$];

  // parser state as predicted
  logic [POS_W-1:0] p_pos;
  phase_t           p_phase;
  logic [15:0]      p_id;
  logic [15:0]      p_flags;
  logic [15:0]      p_counts[4];
  logic [6:0]       p_label_left;
  logic             p_first_label;
  logic [7:0]       p_chars;
  logic [15:0]      p_type_class[2];
  logic [1:0]       p_err;

  function automatic void clear_parser();
    p_pos = '0;
    p_phase = PH_HEADER;
    p_id = '0;
    p_flags = '0;
    foreach (p_counts[i]) p_counts[i] = '0;
    p_label_left = '0;
    p_first_label = 1'b1;
    p_chars = '0;
    p_type_class[0] = '0;
    p_type_class[1] = '0;
    p_err = ST_OK;
  endfunction

  // a word cut short keeps the bytes already seen, high byte first
  function automatic logic [15:0] place_byte(logic [15:0] word, logic odd, logic [7:0] b);
    if (odd) return {word[15:8], b};
    return {b, word[7:0]};
  endfunction

  // characters beyond the name limit are dropped and flag the name as too long
  function automatic void emit_char(logic [7:0] c);
    result_t r;
    if (p_chars >= MAX_NAME) begin
      if (p_err == ST_OK) p_err = ST_LONG;
    end else begin
      r = '0;
      r.kind = KIND_CHAR;
      r.name_char = c;
      expected_results.push_back(r);
      p_chars = p_chars + 8'd1;
    end
  endfunction

  // advance the predicted parser by one accepted byte
  function automatic void predict_byte(logic [7:0] b, logic lastb);
    result_t    s;
    logic [1:0] k;
    int         ci;
    // bytes past the message limit are ignored, only their last mark counts
    if (p_pos < MAX_MESSAGE) begin
      case (p_phase)
        PH_HEADER: begin
          if (p_pos < 2) begin
            p_id = place_byte(p_id, p_pos[0], b);
          end else if (p_pos < 4) begin
            p_flags = place_byte(p_flags, p_pos[0], b);
          end else if (p_pos < HEADER_LEN) begin
            ci = (int'(p_pos) - 4) >> 1;
            p_counts[ci] = place_byte(p_counts[ci], p_pos[0], b);
          end
          if (p_pos == HEADER_LEN - 1) begin
            // QR set or nonzero opcode: skip the question
            if (p_flags[15] || p_flags[14:11] != 4'h0) begin
              p_err = ST_NONSTD;
              p_phase = PH_DONE;
            end else begin
              p_phase = PH_NAME;
            end
          end
        end
        PH_NAME: begin
          if (p_label_left != 0) begin
            emit_char(b);
            p_label_left = p_label_left - 7'd1;
          end else if (b == 8'h00 || b[7]) begin
            p_phase = PH_TAIL;
          end else begin
            if (!p_first_label) emit_char(DOT_CHAR);
            p_first_label = 1'b0;
            p_label_left = b[6:0];
          end
        end
        PH_TAIL: begin
          k = p_label_left[1:0];
          p_type_class[k[1]] = place_byte(p_type_class[k[1]], k[0], b);
          if (k == 2'd3) begin
            p_phase = PH_DONE;
            p_label_left = '0;
          end else begin
            p_label_left = 7'(k) + 7'd1;
          end
        end
        default: ;
      endcase
      p_pos = p_pos + 1'b1;
    end
    if (lastb) begin
      s = '0;
      s.kind = KIND_SUMMARY;
      if (p_err == ST_NONSTD) s.status = ST_NONSTD;
      else if (p_phase != PH_DONE) s.status = ST_TRUNC;
      else if (p_err == ST_LONG) s.status = ST_LONG;
      else s.status = ST_OK;
      s.query_id = p_id;
      s.flag_bits = p_flags;
      s.question_count = p_counts[0];
      s.answer_count = p_counts[1];
      s.authority_count = p_counts[2];
      s.additional_count = p_counts[3];
      s.query_type = p_type_class[0];
      s.query_class = p_type_class[1];
      s.name_length = p_chars;
      expected_results.push_back(s);
      clear_parser();
    end
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // compare one accepted result with the oldest prediction
  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result, kind %0d char %h",
                                out_result_kind, out_name_char));
      return;
    end
    want = expected_results.pop_front();
    check_field("result_kind", 16'(out_result_kind), 16'(want.kind));
    check_field("name_char", 16'(out_name_char), 16'(want.name_char));
    check_field("status", 16'(out_status), 16'(want.status));
    check_field("query_id", out_query_id, want.query_id);
    check_field("flag_bits", out_flag_bits, want.flag_bits);
    check_field("question_count", out_question_count, want.question_count);
    check_field("answer_count", out_answer_count, want.answer_count);
    check_field("authority_count", out_authority_count, want.authority_count);
    check_field("additional_count", out_additional_count, want.additional_count);
    check_field("query_type", out_query_type, want.query_type);
    check_field("query_class", out_query_class, want.query_class);
    check_field("name_length", 16'(out_name_length), 16'(want.name_length));
  endtask

  // result side: check on every accepted result, then pick the next ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result();
    if (ready_hold > 0) begin
      // long hold-off so the result queue fills and the input stalls
      ready_hold = ready_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // offer one byte as a request and wait until it is taken
  task automatic send_byte(logic [7:0] b, logic lastb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= lastb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(b, lastb);
  endtask

  // send the built message, last mark on its final byte
  task automatic send_message();
    foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
  endtask

  // stop offering and wait for every predicted result
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic void push_word(logic [15:0] w);
    msg_bytes.push_back(w[15:8]);
    msg_bytes.push_back(w[7:0]);
  endfunction

  function automatic void push_random(int n);
    repeat (n) msg_bytes.push_back(8'($urandom));
  endfunction

  function automatic void push_label(int len);
    msg_bytes.push_back(8'(len));
    push_random(len);
  endfunction

  // standard header with random id and counts, QR and opcode clear
  function automatic void push_std_header();
    logic [15:0] flags;
    flags = 16'($urandom);
    flags[15:11] = 5'b0;
    push_word(16'($urandom));
    push_word(flags);
    repeat (4) push_word(16'($urandom));
  endfunction

  // mostly well-formed queries with random content, some noise and cut messages
  function automatic void build_random_message();
    int          roll;
    int          len;
    int          cut;
    logic [15:0] flags;
    msg_bytes.delete();
    roll = $urandom_range(99);
    if (roll < 8) begin
      // plain noise
      push_random($urandom_range(1, 24));
      return;
    end
    if (roll < 18) begin
      // response or nonzero opcode, then junk that must be ignored
      flags = 16'($urandom);
      if ($urandom_range(1) == 1) flags[15] = 1'b1;
      else flags[14:11] = 4'($urandom_range(1, 15));
      push_word(16'($urandom));
      push_word(flags);
      repeat (4) push_word(16'($urandom));
      push_random($urandom_range(0, 4));
    end else begin
      push_std_header();
      repeat ($urandom_range(0, 4)) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 10);
        push_label(len);
      end
      // name ends on zero or on a byte with the top bit set
      if ($urandom_range(3) == 0) msg_bytes.push_back(8'($urandom_range(128, 255)));
      else msg_bytes.push_back(8'h00);
      push_random(4);
      push_random($urandom_range(0, 2));
    end
    if ($urandom_range(4) == 0) begin
      cut = $urandom_range(1, msg_bytes.size());
      while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
    end
  endfunction

  // short messages: header cut short, nonstandard query, char on the last byte
  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // id ff80, flags high byte only, QR set but header incomplete
    msg_bytes = '{8'hFF, 8'h80, 8'h80};
    send_message();
    // opcode 15 with extreme counts
    msg_bytes.delete();
    push_word(16'h0000);
    push_word(16'h7800);
    push_word(16'hFFFF);
    push_word(16'h0000);
    push_word(16'hFFFF);
    push_word(16'h0000);
    send_message();
    // every non-QR non-opcode flag set, zero char, dot, char ff marked last
    msg_bytes.delete();
    push_word(16'hFFFF);
    push_word(16'h07FF);
    push_word(16'h0000);
    push_word(16'hFFFF);
    push_word(16'h0000);
    push_word(16'hFFFF);
    msg_bytes.push_back(8'h01);
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'h02);
    msg_bytes.push_back(8'hFF);
    send_message();
    wait_for_drain();
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int budget);
    int sent;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < budget) begin
      build_random_message();
      send_message();
      sent += msg_bytes.size();
    end
    wait_for_drain();
  endtask

  // name runs past the limit, later chars and dots dropped, message complete
  task automatic test_long_name();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    msg_bytes.delete();
    push_std_header();
    repeat (2) push_label(127);
    push_label(5);
    msg_bytes.push_back(8'h00);
    push_random(4);
    send_message();
    wait_for_drain();
  endtask

  // message past the byte limit: the tail is ignored, the last mark still closes it
  task automatic test_overlong_message();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    msg_bytes.delete();
    push_std_header();
    repeat (4) push_label(127);
    while (msg_bytes.size() > MAX_MESSAGE + 8) void'(msg_bytes.pop_back());
    send_message();
    wait_for_drain();
  endtask

  // receiver holds off while the sender keeps offering a char-heavy query
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    ready_hold = 300;
    msg_bytes.delete();
    push_std_header();
    repeat (2) push_label(20);
    msg_bytes.push_back(8'h00);
    push_random(4);
    send_message();
    wait_for_drain();
  endtask

  initial begin
    clear_parser();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_traffic(0, 0, 10);
    test_long_name();
    test_backpressure();
    test_random_traffic(87, 0, 10);
    test_random_traffic(0, 87, 10);
    test_random_traffic(21, 21, 10);
    test_overlong_message();
    // let any stray result show up
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("dns_query_parser test passed");
    end else begin
      $display("dns_query_parser test failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("dns_query_parser test failed");
    $finish;
  end

endmodule
